FILE: rtl/hpbp_pkg.sv
// hpbp_pkg: shared types, constants and hash helpers of the hashed perceptron predictor
// used by hpbp_ctrl, hpbp_dp and the top level; no dependencies
package hpbp_pkg;

    // default sizes
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int HISTORY_BITS_DEF  = 256;
    localparam int WEIGHT_BITS_DEF   = 8;

    // hash constants
    localparam logic [63:0] SEED_MULT   = 64'd1315423911;
    localparam int          CORR_ID     = 99;
    localparam int          FOLD_BITS   = 256;
    localparam int          MAX_CHUNKS  = FOLD_BITS / 32;
    localparam int          WEIGHT_MEMS = 6;
    localparam int          BIAS_SLOT   = 4;
    localparam int          CORR_SLOT   = 5;

    // chunks folded per table: 32, 32, 128, 256 history bits, then 32 for the corrector
    localparam int HIST_CHUNKS [4] = '{1, 1, 4, 8};
    localparam int CORR_CHUNKS     = 1;

    // configuration register indexes
    localparam logic [1:0] CFG_WEIGHT_MAX = 2'd0;
    localparam logic [1:0] CFG_WEIGHT_MIN = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;

    // configuration reset values
    localparam logic [6:0] WEIGHT_MAX_RST = 7'd127;
    localparam logic [7:0] WEIGHT_MIN_RST = 8'h80;
    localparam logic [9:0] THRESHOLD_RST  = 10'd40;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load;
        logic calc;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
    } dp_status_t;

    // seed for a table id: 32-bit product, sign-extended to 64 bits
    function automatic logic [63:0] hash_seed(input int id);
        logic [63:0] prod;
        prod = 64'(id) * SEED_MULT;
        return {{32{prod[31]}}, prod[31:0]};
    endfunction

    // xor and rotate-by-5 folding of 32-bit history chunks
    function automatic logic [63:0] fold_hash(input logic [63:0] pc,
                                              input logic [FOLD_BITS-1:0] hist,
                                              input int nchunks,
                                              input logic [63:0] seed);
        logic [63:0] h;
        h = pc ^ seed;
        for (int c = 0; c < MAX_CHUNKS; c++)
        begin
            if (c < nchunks)
            begin
                h = h ^ {32'd0, hist[c*32 +: 32]};
                h = {h[58:0], h[63:59]};
            end
        end
        return h;
    endfunction

endpackage

FILE: rtl/hpbp_ctrl.sv
// hpbp_ctrl: sequencer of the predictor (table clear, read, compute) and output valid
// depends on hpbp_pkg
module hpbp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hpbp_pkg::dp_cmd_t    cmd,
    input  hpbp_pkg::dp_status_t status
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // take a word only when idle and the result register is free
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign cmd.clear = (state_reg == S_CLEAR);
    assign cmd.load  = accept;
    assign cmd.calc  = (state_reg == S_CALC);

    // next state and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/hpbp_dp.sv
// hpbp_dp: weight memories, hashing, sum, training and history of the predictor
// depends on hpbp_pkg
module hpbp_dp #(
    parameter int TABLE_ENTRIES = hpbp_pkg::TABLE_ENTRIES_DEF,
    parameter int HISTORY_BITS  = hpbp_pkg::HISTORY_BITS_DEF,
    parameter int WEIGHT_BITS   = hpbp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpbp_pkg::dp_cmd_t    cmd,
    output hpbp_pkg::dp_status_t status,
    input  logic                 kind,
    input  logic [63:0]          pc,
    input  logic                 taken,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [9:0]           cfg_data,
    output logic                 predict_taken,
    output logic signed [10:0]   weight_sum,
    output logic                 trained
);

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int SW   = WEIGHT_BITS + 3;
    localparam int CMPW = (SW > 11) ? SW : 11;
    localparam int CW   = 18;
    localparam int NT   = hpbp_pkg::WEIGHT_MEMS;
    localparam logic signed [CW-1:0] W_HI = CW'((1 << (WEIGHT_BITS - 1)) - 1);
    localparam logic signed [CW-1:0] W_LO = -CW'(1 << (WEIGHT_BITS - 1));

    // configuration registers
    logic [6:0] weight_max_reg;
    logic [7:0] weight_min_reg;
    logic [9:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_max_reg <= hpbp_pkg::WEIGHT_MAX_RST;
            weight_min_reg <= hpbp_pkg::WEIGHT_MIN_RST;
            threshold_reg  <= hpbp_pkg::THRESHOLD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hpbp_pkg::CFG_WEIGHT_MAX: weight_max_reg <= cfg_data[6:0];
                hpbp_pkg::CFG_WEIGHT_MIN: weight_min_reg <= cfg_data[7:0];
                hpbp_pkg::CFG_THRESHOLD:  threshold_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // global history, bit 0 newest
    logic [HISTORY_BITS-1:0]        hist_reg;
    logic [hpbp_pkg::FOLD_BITS-1:0] hist_pad;

    for (genvar b = 0; b < hpbp_pkg::FOLD_BITS; b++)
    begin : g_pad
        if (b < HISTORY_BITS)
        begin : g_bit
            assign hist_pad[b] = hist_reg[b];
        end
        else
        begin : g_zero
            assign hist_pad[b] = 1'b0;
        end
    end

    // table indexes from the incoming word
    logic [AW-1:0] idx [NT];

    for (genvar t = 0; t < 4; t++)
    begin : g_hidx
        localparam logic [63:0] SEED = hpbp_pkg::hash_seed(t);
        logic [63:0] h;
        assign h      = hpbp_pkg::fold_hash(pc, hist_pad, hpbp_pkg::HIST_CHUNKS[t], SEED);
        assign idx[t] = h[AW-1:0];
    end

    localparam logic [63:0] CORR_SEED = hpbp_pkg::hash_seed(hpbp_pkg::CORR_ID);
    logic [63:0] corr_h;
    assign corr_h = hpbp_pkg::fold_hash(pc, hist_pad, hpbp_pkg::CORR_CHUNKS, CORR_SEED);
    assign idx[hpbp_pkg::BIAS_SLOT] = pc[AW-1:0];
    assign idx[hpbp_pkg::CORR_SLOT] = corr_h[AW-1:0];

    // captured word and indexes
    logic          kind_reg;
    logic          taken_reg;
    logic [AW-1:0] idx_reg [NT];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            taken_reg <= taken;
            idx_reg   <= idx;
        end
    end

    // clearing sweep counter
    logic [AW-1:0] clr_addr_reg;
    assign status.clear_last = (clr_addr_reg == {AW{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // sum and training decision
    logic signed [WEIGHT_BITS-1:0] rd_reg [NT];
    logic signed [SW-1:0]          sum;
    logic [SW-1:0]                 abs_sum;
    logic                          pred;
    logic                          do_train;

    always_comb
    begin
        sum = '0;
        for (int t = 0; t < NT; t++)
        begin
            sum = sum + SW'(rd_reg[t]);
        end
        pred     = !sum[SW-1];
        abs_sum  = sum[SW-1] ? SW'(-sum) : SW'(sum);
        do_train = kind_reg &&
                   ((pred != taken_reg) || (CMPW'(abs_sum) < CMPW'(threshold_reg)));
    end

    // saturating step of each weight
    logic signed [WEIGHT_BITS-1:0] new_w [NT];
    logic signed [CW-1:0]          wmax_ext;
    logic signed [CW-1:0]          wmin_ext;

    assign wmax_ext = CW'({1'b0, weight_max_reg});
    assign wmin_ext = CW'(signed'(weight_min_reg));

    always_comb
    begin
        logic signed [CW-1:0] v;
        for (int t = 0; t < NT; t++)
        begin
            v = CW'(rd_reg[t]) + (taken_reg ? CW'(1) : -CW'(1));
            if (v > wmax_ext)
            begin
                v = wmax_ext;
            end
            else if (v < wmin_ext)
            begin
                v = wmin_ext;
            end
            if (v > W_HI)
            begin
                v = W_HI;
            end
            if (v < W_LO)
            begin
                v = W_LO;
            end
            new_w[t] = v[WEIGHT_BITS-1:0];
        end
    end

    // six weight memories: clear sweep, read on load, write back on training
    for (genvar t = 0; t < NT; t++)
    begin : g_mem
        logic [WEIGHT_BITS-1:0] mem [TABLE_ENTRIES];

        always_ff @(posedge clk)
        begin
            if (cmd.clear)
            begin
                mem[clr_addr_reg] <= '0;
            end
            else if (cmd.calc && do_train)
            begin
                mem[idx_reg[t]] <= new_w[t];
            end
            if (cmd.load)
            begin
                rd_reg[t] <= mem[idx[t]];
            end
        end
    end

    // history shift on update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (cmd.calc && kind_reg)
        begin
            hist_reg <= {hist_reg[HISTORY_BITS-2:0], taken_reg};
        end
    end

    // result word register
    logic signed [10:0] sum_sat;

    always_comb
    begin
        if (CMPW'(sum) > CMPW'(1023))
        begin
            sum_sat = 11'sd1023;
        end
        else if (CMPW'(sum) < -CMPW'(1024))
        begin
            sum_sat = -11'sd1024;
        end
        else
        begin
            sum_sat = 11'(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            predict_taken <= pred;
            weight_sum    <= sum_sat;
            trained       <= do_train;
        end
    end

endmodule

FILE: rtl/hashed_perceptron_branch_predictor.sv
// hashed perceptron branch predictor: an accepted word's weights are read into registers, then the
// compute state registers the result and raises out_valid
// one word in flight at a time, set by the read then write-back of the weight memories
// after reset the six weight memories are cleared, one entry a cycle, before in_ready rises;
// configuration writes are taken at any time
// config registers reset to weight_max 127, weight_min -128, train_threshold 40
// depends on hpbp_pkg, hpbp_ctrl, hpbp_dp
module hashed_perceptron_branch_predictor #(
    parameter int TABLE_ENTRIES = hpbp_pkg::TABLE_ENTRIES_DEF,
    parameter int HISTORY_BITS  = hpbp_pkg::HISTORY_BITS_DEF,
    parameter int WEIGHT_BITS   = hpbp_pkg::WEIGHT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [63:0]        pc,
    input  logic               taken,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               predict_taken,
    output logic signed [10:0] weight_sum,
    output logic               trained,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data
);

    hpbp_pkg::dp_cmd_t    cmd;
    hpbp_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    hpbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    hpbp_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HISTORY_BITS  (HISTORY_BITS),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .pc            (pc),
        .taken         (taken),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .predict_taken (predict_taken),
        .weight_sum    (weight_sum),
        .trained       (trained)
    );

`ifndef SYNTHESIS
    // one word in flight: no new word the cycle after an accept
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word accepted while previous word in flight");

    // a result appears only in the cycle after the compute state
    a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.calc))
        else $error("result without a computed word");

    // prediction agrees with the sign of the reported sum
    a_pred_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (predict_taken == !weight_sum[10]))
        else $error("prediction disagrees with sum sign");
`endif

endmodule
